// ===== sv/hre_pkg.sv =====
// Package for the HFI rotor angle estimator: item types, register indexes,
// quarter-wave sine table function and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package hre_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AMP = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_POL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KI = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ADT = 3'd5;

  localparam logic [1:0] MODE_TRACK = 2'd0;
  localparam logic [1:0] MODE_POLARITY = 2'd1;
  localparam logic [1:0] MODE_INJECT = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [15:0] i_alpha;
    logic signed [15:0] i_beta;
    logic signed [15:0] u_alpha;
    logic signed [15:0] u_beta;
    logic signed [15:0] id_target;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] u_alpha_out;
    logic signed [15:0] u_beta_out;
    logic [15:0] angle_estimate;
    logic signed [31:0] speed_estimate;
    logic signed [15:0] i_alpha_fund;
    logic signed [15:0] i_beta_fund;
    logic signed [15:0] angle_error;
    logic [39:0] sum_pos;
    logic [39:0] sum_neg;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [14:0] injection_amplitude;
    logic [15:0] polarity_offset;
    logic [15:0] pll_kp;
    logic [15:0] pll_ki_dt;
    logic [15:0] angle_dt;
  } cfg_t;

  // Quarter-wave entry k of n=2^bits by integer Taylor series (elaboration only).
  function automatic logic [15:0] qtab_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] t;
    longint sum;
    longint e;
    x = (64'(k) * 64'd1686629713) >> bits;
    t = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      t = (((t * x) >> 30) * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    e = (sum + 16384) >>> 15;
    if (e > 32767) e = 32767;
    return 16'(e);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/hre_sine.sv =====
// Sine lookup: quarter-wave table built from hre_pkg::qtab_entry.
// Depends on hre_pkg.
`timescale 1ns / 1ps
module hre_sine import hre_pkg::*; #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic [15:0]        phase,
  output logic signed [15:0] value
);
  localparam int N = 1 << SINE_TABLE_BITS;
  localparam int IW = SINE_TABLE_BITS + 2;

  logic [15:0] qtab [N+1];
  logic [IW-1:0] idx;
  logic [1:0] quad;
  logic [SINE_TABLE_BITS-1:0] w;
  logic [SINE_TABLE_BITS:0] addr;
  logic signed [15:0] v;

  for (genvar k = 0; k <= N; k++) begin : g_tab
    assign qtab[k] = qtab_entry(k, SINE_TABLE_BITS);
  end

  assign idx = phase[15 -: IW];
  assign quad = idx[IW-1 -: 2];
  assign w = idx[SINE_TABLE_BITS-1:0];
  assign addr = quad[0] ? ((SINE_TABLE_BITS+1)'(N) - {1'b0, w}) : {1'b0, w};
  assign v = qtab[addr];
  assign value = quad[1] ? -v : v;
endmodule

// ===== sv/hre_mac.sv =====
// Shared signed multiply unit with registered product; one product per cycle.
// Depends on hre_pkg.
`timescale 1ns / 1ps
module hre_mac import hre_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [16:0] b,
  output logic signed [49:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ===== sv/hfi_rotor_angle_estimator_top.sv =====
// Top level of the HFI rotor angle estimator: config registers, sequencer,
// shared multiplier and sine table. Depends on hre_pkg, hre_sine, hre_mac.
//
// Usage: one input item per PWM period on in_valid/in_ready carrying the
// measured currents, commanded voltages and id target. One result item per
// input on out_valid/out_ready with the injected voltages, angle, speed,
// fundamental currents, phase error and polarity sums.
// The sequencer steps through the single registered multiplier in order: cos
// and sin injection products, two phase detector products, then kp, ki and
// angle_dt products when tracking, so tracking mode takes more steps than the
// other modes. A new item is not taken before the last one is finished:
// in_ready is low while an item is in work.
// A finished result moves into the output register once it is free; while
// the previous result still waits there, the sequencer holds and in_ready
// stays low.
// Reset clears filter history, loop state, sums and restores register
// defaults; the sine table is constant logic, so no fill pass is needed.
// Configuration writes take effect at once and belong to idle periods.
`timescale 1ns / 1ps
module hfi_rotor_angle_estimator_top import hre_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
    S_M11, S_DONE
  } state_t;

  state_t state;
  cfg_t cfg;
  in_item_t item;
  logic signed [15:0] a_prev, b_prev, a_prev2, b_prev2;
  logic inj_pos;
  logic [ANGLE_BITS-1:0] angle_reg;
  logic signed [31:0] speed_reg, integ, integ_next;
  logic [39:0] pos_acc, neg_acc;
  logic signed [15:0] hfa, hfb, lfa, lfb, uao, ubo, err, ud;
  logic signed [47:0] acc;
  logic signed [31:0] pterm;
  logic [15:0] ang16, inj16, ph;
  logic signed [15:0] sinv;
  logic signed [32:0] ma;
  logic signed [16:0] mb;
  logic signed [49:0] prod;
  logic res_pending;
  logic res_load;
  out_item_t res, res_next;

  function automatic logic [15:0] to16(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS+15:0] t;
    t = {a, 16'd0};
    return t[ANGLE_BITS+15 -: 16];
  endfunction

  function automatic logic [ANGLE_BITS-1:0] from16(input logic [15:0] p);
    logic [ANGLE_BITS+15:0] t;
    t = {p, (ANGLE_BITS)'(0)};
    return t[ANGLE_BITS+15 -: ANGLE_BITS];
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [47:0] s);
    logic signed [47:0] r;
    r = (s + 48'sd16384) >>> 15;
    return sat16(r);
  endfunction

  hre_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (.phase(ph), .value(sinv));
  hre_mac u_mac (.clk(clk), .a(ma), .b(mb), .p(prod));

  assign ang16 = to16(angle_reg);
  assign inj16 = to16(angle_reg + from16(cfg.polarity_offset));

  logic signed [17:0] hfa_w, hfb_w, lfa_w, lfb_w;
  assign hfa_w = 18'(item.i_alpha) - 18'(a_prev) * 18'sd2 + 18'(a_prev2);
  assign hfb_w = 18'(item.i_beta) - 18'(b_prev) * 18'sd2 + 18'(b_prev2);
  assign lfa_w = 18'(item.i_alpha) + 18'(a_prev) * 18'sd2 + 18'(a_prev2);
  assign lfb_w = 18'(item.i_beta) + 18'(b_prev) * 18'sd2 + 18'(b_prev2);

  // Multiplier operand and table phase per step; the product is registered in hre_mac.
  always_comb begin
    ph = inj16 + 16'd16384;
    ma = 33'(ud);
    mb = 17'(sinv);
    case (state)
      S_M1: ph = inj16 + 16'd16384;
      S_M2: ph = inj16;
      S_M3: begin
        ph = ang16;
        ma = (cfg.mode == MODE_TRACK) ? -33'(hfa) : 33'(hfb);
      end
      S_M4: begin
        ph = ang16 + 16'd16384;
        ma = (cfg.mode == MODE_TRACK) ? 33'(hfb) : 33'(hfa);
      end
      S_M7: begin
        ma = 33'(err);
        mb = 17'(cfg.pll_kp);
      end
      S_M8: begin
        ma = 33'(err);
        mb = 17'(cfg.pll_ki_dt);
      end
      S_M10: begin
        ma = 33'(speed_reg);
        mb = 17'(cfg.angle_dt);
      end
      default: ;
    endcase
  end

  logic signed [47:0] prod48;
  logic signed [63:0] dlt;
  logic [39:0] mag40;
  logic [40:0] sum41;
  assign prod48 = prod[47:0];
  assign dlt = (64'(prod) + 64'sd2147483648) >>> 32;
  assign mag40 = 40'(q15(acc) < 0 ? -17'(q15(acc)) : 17'(q15(acc)));
  assign sum41 = {1'b0, (item.id_target > 0) ? pos_acc : neg_acc} + {1'b0, mag40};
  assign integ_next = sat32(48'(integ) + 48'(sat32(prod48 <<< 8)));

  assign in_ready = (state == S_IDLE);
  assign out_data = res;
  assign out_valid = res_pending;
  assign res_load = (state == S_DONE) && (!res_pending || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cfg <= '{mode: 2'd0, injection_amplitude: 15'd2458, polarity_offset: 16'd0,
               pll_kp: 16'd256, pll_ki_dt: 16'd16, angle_dt: 16'd1024};
      a_prev <= '0; b_prev <= '0; a_prev2 <= '0; b_prev2 <= '0;
      inj_pos <= 1'b1;
      angle_reg <= '0;
      speed_reg <= '0;
      integ <= '0;
      pos_acc <= '0;
      neg_acc <= '0;
      res_pending <= 1'b0;
    end else begin
      if (res_load) res_pending <= 1'b1;
      else if (out_ready) res_pending <= 1'b0;
      if (res_load) res <= res_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: cfg.mode <= cfg_data[1:0];
          REG_AMP: cfg.injection_amplitude <= cfg_data[14:0];
          REG_POL: cfg.polarity_offset <= cfg_data;
          REG_KP: cfg.pll_kp <= cfg_data;
          REG_KI: cfg.pll_ki_dt <= cfg_data;
          REG_ADT: cfg.angle_dt <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          state <= S_M0;
        end
        S_M0: begin
          hfa <= 16'(hfa_w >>> 2); hfb <= 16'(hfb_w >>> 2);
          lfa <= 16'(lfa_w >>> 2); lfb <= 16'(lfb_w >>> 2);
          a_prev2 <= a_prev; b_prev2 <= b_prev;
          a_prev <= item.i_alpha; b_prev <= item.i_beta;
          inj_pos <= !inj_pos;
          ud <= inj_pos ? -16'(cfg.injection_amplitude) : 16'(cfg.injection_amplitude);
          err <= '0;
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          uao <= sat16(48'(item.u_alpha) + 48'(q15(prod48)));
          state <= S_M3;
        end
        S_M3: begin
          ubo <= sat16(48'(item.u_beta) + 48'(q15(prod48)));
          state <= S_M4;
        end
        S_M4: begin
          acc <= prod48;
          state <= S_M5;
        end
        S_M5: begin
          acc <= acc + prod48;
          state <= S_M6;
        end
        S_M6: begin
          if (cfg.mode == MODE_TRACK) begin
            err <= q15(acc);
            state <= S_M7;
          end else begin
            if (cfg.mode == MODE_POLARITY) begin
              if (item.id_target > 0)
                pos_acc <= sum41[40] ? '1 : sum41[39:0];
              else if (item.id_target < 0)
                neg_acc <= sum41[40] ? '1 : sum41[39:0];
            end
            state <= S_DONE;
          end
        end
        S_M7: state <= S_M8;
        S_M8: begin
          pterm <= sat32(prod48 <<< 8);
          state <= S_M9;
        end
        S_M9: begin
          integ <= integ_next;
          speed_reg <= sat32(48'(pterm) + 48'(integ_next));
          state <= S_M10;
        end
        S_M10: state <= S_M11;
        S_M11: begin
          angle_reg <= angle_reg + dlt[ANGLE_BITS-1:0];
          state <= S_DONE;
        end
        S_DONE: if (res_load) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_next.u_alpha_out = uao;
    res_next.u_beta_out = ubo;
    res_next.angle_estimate = to16(angle_reg);
    res_next.speed_estimate = speed_reg;
    res_next.i_alpha_fund = lfa;
    res_next.i_beta_fund = lfb;
    res_next.angle_error = err;
    res_next.sum_pos = pos_acc;
    res_next.sum_neg = neg_acc;
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_M0)) else $error("accept lost");
  a_err: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cfg.mode != MODE_TRACK) |-> (err == 16'sd0))
    else $error("error nonzero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped while stalled");
`endif
endmodule
